@@ hdl/frcr_pkg.sv @@
package frcr_pkg;

  localparam int MAX_FRAME     = 256;
  localparam int PAYLOAD_BYTES = 16;

  // payload counter holds 0..MAX_FRAME
  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int IDX_W = $clog2(PAYLOAD_BYTES);
  localparam int LEN_W = 9;
  localparam int LEN_MAX = (1 << LEN_W) - 1;

  localparam logic [7:0] HEAD_RESET = 8'h7E;
  localparam logic [7:0] TAIL_RESET = 8'h7F;

  // register index, taken from paddr[2]
  localparam logic REG_HEAD = 1'b0;
  localparam logic REG_TAIL = 1'b1;

  localparam logic [2:0] MOTION_STAND   = 3'd0;
  localparam logic [2:0] MOTION_FORWARD = 3'd1;
  localparam logic [2:0] MOTION_RIGHT   = 3'd2;
  localparam logic [2:0] MOTION_BACK    = 3'd3;
  localparam logic [2:0] MOTION_LEFT    = 3'd4;

  typedef logic [PAYLOAD_BYTES-1:0][7:0] payload_t;

  typedef struct packed {
    logic             commit;
    logic [CNT_W-1:0] length;
  } frcr_commit_t;

endpackage

@@ hdl/framed_remote_control_receiver_unit.sv @@
// Framed remote control receiver. Received bytes enter one word per cycle on
// the s_axis side; each byte yields exactly one m_axis word in the next cycle,
// so the sustained rate is one byte per clock. A byte equal to head_byte opens
// (or restarts) a frame; a byte equal to tail_byte closes it and, for a
// nonempty payload, commits its first 16 bytes over the held payload. A frame
// whose payload grows past MAX_FRAME bytes is discarded and flagged. Each
// result word carries the done/dropped flags of its byte plus the held
// payload as four big-endian channels, eight key bytes and a motion command.
// The latency and rate are set by the single result register; while a result
// waits on m_axis_tready the input stalls. head_byte (0x0) and tail_byte (0x4)
// sit on the APB port and are meant to be written while the stream is idle.
module framed_remote_control_receiver_unit
  import frcr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  // APB configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // byte input
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] rx_byte
  // result output
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [143:0]  m_axis_tdata,   // [8:0] frame_length, [24:9] channel_0,
                                        // [40:25] channel_1, [56:41] channel_2,
                                        // [72:57] channel_3, [136:73] key_bytes,
                                        // [139:137] motion_command, rest zero
  output logic [1:0]    m_axis_tuser    // [0] frame_done, [1] frame_dropped
);

  logic [7:0]       head_byte, tail_byte;
  logic             accept;
  frcr_commit_t     commit;
  logic             done, dropped;
  logic             done_q, dropped_q;
  payload_t         staging, held;
  logic [LEN_W-1:0] frame_length;
  logic [2:0]       motion_command;

  // APB: always ready, register picked by paddr[2]
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte <= HEAD_RESET;
      tail_byte <= TAIL_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_HEAD: head_byte <= pwdata[7:0];
        REG_TAIL: tail_byte <= pwdata[7:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HEAD: prdata = {24'd0, head_byte};
      REG_TAIL: prdata = {24'd0, tail_byte};
      default:  prdata = '0;
    endcase
  end

  // take a byte whenever the result slot is empty or being drained
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  frcr_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (s_axis_tdata),
    .head_byte (head_byte),
    .tail_byte (tail_byte),
    .commit    (commit),
    .done      (done),
    .dropped   (dropped),
    .staging   (staging)
  );

  // held payload updates at the accept edge, so it is the result payload
  // of the word now in the output register
  frcr_hold u_hold (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .commit         (commit),
    .staging        (staging),
    .held           (held),
    .frame_length   (frame_length),
    .motion_command (motion_command)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      done_q    <= done;
      dropped_q <= dropped;
    end
  end

  assign m_axis_tuser = {dropped_q, done_q};

  assign m_axis_tdata = {
    4'd0,
    motion_command,
    held[15], held[14], held[13], held[12], held[11], held[10], held[9], held[8],
    held[6], held[7],
    held[4], held[5],
    held[2], held[3],
    held[0], held[1],
    frame_length
  };

endmodule

@@ hdl/frcr_framer.sv @@
module frcr_framer
  import frcr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [7:0]   rx_byte,
  input  logic [7:0]   head_byte,
  input  logic [7:0]   tail_byte,
  output frcr_commit_t commit,
  output logic         done,
  output logic         dropped,
  output payload_t     staging
);

  logic             frame_open, frame_open_next;
  logic [CNT_W-1:0] count, count_next;
  logic             stage_we;

  always_comb begin
    frame_open_next = frame_open;
    count_next      = count;
    stage_we        = 1'b0;
    done            = 1'b0;
    dropped         = 1'b0;
    commit.commit   = 1'b0;
    commit.length   = count;
    if (rx_byte == head_byte) begin
      // head always restarts, wins over tail when both match
      frame_open_next = 1'b1;
      count_next      = '0;
    end else if (frame_open) begin
      if (rx_byte == tail_byte) begin
        commit.commit   = (count != '0);
        frame_open_next = 1'b0;
        count_next      = '0;
        done            = 1'b1;
      end else if (count < CNT_W'(MAX_FRAME)) begin
        stage_we   = (count < CNT_W'(PAYLOAD_BYTES));
        count_next = count + 1'b1;
      end else begin
        frame_open_next = 1'b0;
        count_next      = '0;
        dropped         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      count      <= '0;
    end else if (accept) begin
      frame_open <= frame_open_next;
      count      <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && stage_we) begin
      staging[count[IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule

@@ hdl/frcr_hold.sv @@
module frcr_hold
  import frcr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  frcr_commit_t     commit,
  input  payload_t         staging,
  output payload_t         held,
  output logic [LEN_W-1:0] frame_length,
  output logic [2:0]       motion_command
);

  logic [CNT_W-1:0] held_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      held        <= '0;
      held_length <= '0;
    end else if (accept && commit.commit) begin
      held_length <= commit.length;
      // short frame: positions past the length keep older bytes
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        if (commit.length > CNT_W'(i)) begin
          held[i] <= staging[i];
        end
      end
    end
  end

  always_comb begin
    if (held_length > CNT_W'(LEN_MAX)) begin
      frame_length = LEN_W'(LEN_MAX);
    end else begin
      frame_length = LEN_W'(held_length);
    end
  end

  // first of keys 0..3 equal to one
  always_comb begin
    if (held[8] == 8'd1) begin
      motion_command = MOTION_FORWARD;
    end else if (held[9] == 8'd1) begin
      motion_command = MOTION_RIGHT;
    end else if (held[10] == 8'd1) begin
      motion_command = MOTION_BACK;
    end else if (held[11] == 8'd1) begin
      motion_command = MOTION_LEFT;
    end else begin
      motion_command = MOTION_STAND;
    end
  end

endmodule
